FILE: src/path_point_heading_annotator_assert.svh
// ----------------------------------------------------------------------------
// path point heading annotator assertion macros
// concurrent checks that compile away when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef PATH_POINT_HEADING_ANNOTATOR_ASSERT_SVH
`define PATH_POINT_HEADING_ANNOTATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PPHA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppha: same-cycle check failed");
// next-cycle implication
`define PPHA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppha: next-cycle check failed");
`else
`define PPHA_ASSERT_IMP(label, clk, rst, ante, cons)
`define PPHA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/ppha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppha_pkg
// shared types, constants and the arctangent table of the heading annotator
// ----------------------------------------------------------------------------
package ppha_pkg;

  localparam int PRESCALE  = 24;
  localparam int Z_W       = 35;
  localparam int HEAD_W    = 16;
  localparam int OUT_SHIFT = 17;

  localparam logic signed [Z_W-1:0] PI_Q30    = 35'sd3373259426;
  localparam logic signed [Z_W-1:0] ROUND_Q30 = 35'sd65536;
  localparam logic signed [Z_W-1:0] HEAD_MAX  = 35'sd25736;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT_FIRST,
    ST_EMIT_SECOND
  } ppha_state_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_PREP,
    CS_ITER,
    CS_FINAL
  } cord_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cord_status_t;

  // atan(2^-i) in Q30, rounded; steps past the table add nothing
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [Z_W-1:0] val;
    case (idx)
      5'd0:    val = 35'sd843314857;
      5'd1:    val = 35'sd497837829;
      5'd2:    val = 35'sd263043837;
      5'd3:    val = 35'sd133525159;
      5'd4:    val = 35'sd67021687;
      5'd5:    val = 35'sd33543516;
      5'd6:    val = 35'sd16775851;
      5'd7:    val = 35'sd8388437;
      5'd8:    val = 35'sd4194283;
      5'd9:    val = 35'sd2097149;
      5'd10:   val = 35'sd1048576;
      5'd11:   val = 35'sd524288;
      5'd12:   val = 35'sd262144;
      5'd13:   val = 35'sd131072;
      5'd14:   val = 35'sd65536;
      5'd15:   val = 35'sd32768;
      5'd16:   val = 35'sd16384;
      5'd17:   val = 35'sd8192;
      5'd18:   val = 35'sd4096;
      5'd19:   val = 35'sd2048;
      5'd20:   val = 35'sd1024;
      5'd21:   val = 35'sd512;
      5'd22:   val = 35'sd256;
      5'd23:   val = 35'sd128;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

FILE: src/ppha_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppha_cordic
// iterative vectoring cordic: atan2 of a step vector, one rotation per cycle
// ----------------------------------------------------------------------------
module ppha_cordic #(
  parameter int COORD_BITS       = 24,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [COORD_BITS:0]             step_x,
  input  logic signed [COORD_BITS:0]             step_y,
  output ppha_pkg::cord_status_t                 status,
  output logic signed [ppha_pkg::HEAD_W-1:0]     heading
);
  import ppha_pkg::*;

  localparam int EXT_W  = 3;
  localparam int W      = COORD_BITS + 1 + PRESCALE + EXT_W;
  localparam int ITER_W = $clog2(ANGLE_ITERATIONS);
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ANGLE_ITERATIONS - 1);

  cord_state_t state, state_next;

  logic signed [W-1:0]     x, y;
  logic signed [W-1:0]     xs, ys;
  logic signed [Z_W-1:0]   z;
  logic signed [Z_W-1:0]   angle;
  logic signed [Z_W-1:0]   rounded, scaled;
  logic [ITER_W-1:0]       iter;

  assign xs    = x >>> iter;
  assign ys    = y >>> iter;
  assign angle = atan_q30(5'(iter));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    status.busy = (state != CS_IDLE);
    status.done = (state == CS_FINAL);
    case (state)
      CS_IDLE: begin
        if (start) state_next = CS_PREP;
      end
      CS_PREP:  state_next = CS_ITER;
      CS_ITER: begin
        if (iter == LAST_ITER) state_next = CS_FINAL;
      end
      CS_FINAL: state_next = CS_IDLE;
      default:  state_next = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (state == CS_PREP) begin
      iter <= '0;
    end else if (state == CS_ITER) begin
      iter <= iter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      CS_IDLE: begin
        if (start) begin
          x <= {{EXT_W{step_x[COORD_BITS]}}, step_x, {PRESCALE{1'b0}}};
          y <= {{EXT_W{step_y[COORD_BITS]}}, step_y, {PRESCALE{1'b0}}};
          z <= '0;
        end
      end
      CS_PREP: begin
        // left half plane: fold over and start from plus or minus pi
        if (x[W-1]) begin
          x <= -x;
          y <= -y;
          z <= y[W-1] ? -PI_Q30 : PI_Q30;
        end
      end
      CS_ITER: begin
        if (!y[W-1]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + angle;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - angle;
        end
      end
      default: begin
      end
    endcase
  end

  // round Q4.30 to Q2.13 and clamp to plus or minus pi
  always_comb begin
    rounded = z + ROUND_Q30;
    scaled  = rounded >>> OUT_SHIFT;
    if (scaled > HEAD_MAX) begin
      heading = HEAD_W'(HEAD_MAX);
    end else if (scaled < -HEAD_MAX) begin
      heading = HEAD_W'(-HEAD_MAX);
    end else begin
      heading = HEAD_W'(scaled);
    end
  end

endmodule
`default_nettype wire

FILE: src/path_point_heading_annotator.sv
`timescale 1ns / 1ps
`default_nettype none
// a point that starts the cordic holds in_stall through the cordic's prep,
//   iteration and final states and then until its pose is taken, or until both
//   poses are taken when the held first pose goes out too; a point that yields
//   none is taken without a stall; the cordic does one rotation per cycle
// reset clears the path state and both sequencers at once, no clearing pass
// ----------------------------------------------------------------------------
// path_point_heading_annotator
// turns path points into poses whose heading is atan2 of the step between them
// ----------------------------------------------------------------------------
`include "path_point_heading_annotator_assert.svh"
module path_point_heading_annotator #(
  parameter int COORD_BITS       = 24,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [COORD_BITS-1:0]           point_x,
  input  logic signed [COORD_BITS-1:0]           point_y,
  input  logic                                   path_end,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [COORD_BITS-1:0]           pose_x,
  output logic signed [COORD_BITS-1:0]           pose_y,
  output logic signed [ppha_pkg::HEAD_W-1:0]     pose_heading,
  output logic                                   run_last
);
  import ppha_pkg::*;

  ppha_state_t state, state_next;

  logic signed [COORD_BITS-1:0] prev_x, prev_y;
  logic signed [COORD_BITS-1:0] held_x, held_y;
  logic signed [COORD_BITS-1:0] cur_x, cur_y;
  logic signed [HEAD_W-1:0]     heading_q;
  logic signed [HEAD_W-1:0]     cord_heading;
  logic signed [COORD_BITS:0]   step_x, step_y;
  logic                         have_prev;
  logic                         first_pending;
  logic                         emit_first;
  logic                         step_zero;
  logic                         in_accept;
  logic                         cord_start;
  cord_status_t                 cord_status;

  assign step_x     = {point_x[COORD_BITS-1], point_x} - {prev_x[COORD_BITS-1], prev_x};
  assign step_y     = {point_y[COORD_BITS-1], point_y} - {prev_y[COORD_BITS-1], prev_y};
  assign step_zero  = (point_x == prev_x) && (point_y == prev_y);
  assign in_accept  = in_valid && !in_stall;
  assign cord_start = in_accept && have_prev && !step_zero;

  ppha_cordic #(
    .COORD_BITS       (COORD_BITS),
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cord_start),
    .step_x  (step_x),
    .step_y  (step_y),
    .status  (cord_status),
    .heading (cord_heading)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE);
    out_valid  = (state == ST_EMIT_FIRST) || (state == ST_EMIT_SECOND);
    run_last   = (state == ST_EMIT_SECOND);
    case (state)
      ST_IDLE: begin
        if (cord_start) state_next = ST_CALC;
      end
      ST_CALC: begin
        if (cord_status.done) state_next = emit_first ? ST_EMIT_FIRST : ST_EMIT_SECOND;
      end
      ST_EMIT_FIRST: begin
        if (!out_stall) state_next = ST_EMIT_SECOND;
      end
      ST_EMIT_SECOND: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // path state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x        <= '0;
      prev_y        <= '0;
      have_prev     <= 1'b0;
      first_pending <= 1'b0;
      emit_first    <= 1'b0;
    end else if (in_accept) begin
      if (cord_start) emit_first <= first_pending;
      if (path_end) begin
        prev_x        <= '0;
        prev_y        <= '0;
        have_prev     <= 1'b0;
        first_pending <= 1'b0;
      end else begin
        prev_x        <= point_x;
        prev_y        <= point_y;
        have_prev     <= 1'b1;
        first_pending <= !have_prev;
      end
    end
  end

  // pose payload
  always_ff @(posedge clk) begin
    if (cord_start) begin
      held_x <= prev_x;
      held_y <= prev_y;
      cur_x  <= point_x;
      cur_y  <= point_y;
    end
    if (cord_status.done) heading_q <= cord_heading;
  end

  assign pose_x       = (state == ST_EMIT_FIRST) ? held_x : cur_x;
  assign pose_y       = (state == ST_EMIT_FIRST) ? held_y : cur_y;
  assign pose_heading = heading_q;

  `PPHA_ASSERT_IMP(a_no_overlap, clk, rst, !in_stall, !out_valid)
  `PPHA_ASSERT_IMP(a_done_in_calc, clk, rst, cord_status.done, state == ST_CALC)
  `PPHA_ASSERT_IMP(a_busy_in_calc, clk, rst, state == ST_CALC, cord_status.busy)
  `PPHA_ASSERT_NXT(a_pair_closes, clk, rst, out_valid && !out_stall && !run_last, out_valid && run_last)
  `PPHA_ASSERT_NXT(a_ready_after_last, clk, rst, out_valid && !out_stall && run_last, !in_stall)

endmodule
`default_nettype wire
